[sv/mrh_pkg.sv]
// Shared constants and widths for the multiply-rotate hash block.
package mrh_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW   = 32;
  localparam int unsigned HalfW  = WordW / 2;
  localparam int unsigned BytesPerWord = WordW / 8;

  localparam logic [WordW-1:0] MixPrimeA = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixPrimeB = 64'h6c62272e07bb0142;
  localparam logic [WordW-1:0] MixAddend = 64'h94d049bb133111eb;

  localparam int unsigned RoundRot  = 27;
  localparam int unsigned FinShift1 = 33;
  localparam int unsigned FinShift2 = 29;
  localparam int unsigned FinShift3 = 32;

endpackage

[sv/mrh_in_if.sv]
// Input channel: one message word with its byte count and end marker.
interface mrh_in_if;
  logic                              valid;
  logic                              ready;
  logic [mrh_pkg::WordW-1:0]         data_word;
  logic [mrh_pkg::CountW-1:0]        byte_count;
  logic                              last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

[sv/mrh_out_if.sv]
// Output channel: the finished 64-bit digest of a message.
interface mrh_out_if;
  logic                      valid;
  logic                      ready;
  logic [mrh_pkg::WordW-1:0] digest;

  modport source (output valid, output digest, input ready);
  modport sink   (input valid, input digest, output ready);
endinterface

[sv/multiply_rotate_hash64.sv]
// Top level of the streaming multiply-rotate 64-bit hash.
// Each 64-bit multiply uses one shared 32x32 multiplier (three partial products
// and a 32-bit add). A word with data takes two multiplies and holds ready low until they are done,
// so no new word is taken meanwhile; a word with no bytes and no end marker leaves the block idle.
// A last word adds two finishing multiplies; the finished digest waits in a register, and input is
// held off only while a newly finished digest waits for that register to be free.
module multiply_rotate_hash64 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mrh_pkg::LenW-1:0]     cfg_wdata_i,
  mrh_in_if.sink                       in_i,
  mrh_out_if.source                    out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MUL  = 1'b1;

  localparam logic [1:0] OP_ABS_A = 2'd0;
  localparam logic [1:0] OP_ABS_B = 2'd1;
  localparam logic [1:0] OP_FIN_A = 2'd2;
  localparam logic [1:0] OP_FIN_B = 2'd3;

  localparam logic [1:0] STEP_LAST = 2'd3;

  localparam int unsigned W = mrh_pkg::WordW;
  localparam int unsigned H = mrh_pkg::HalfW;

  logic                     state_q, state_d;
  logic [1:0]               op_q, op_d;
  logic [1:0]               cnt_q, cnt_d;
  logic                     in_msg_q, in_msg_d;
  logic                     last_q, last_d;
  logic [mrh_pkg::LenW-1:0] len_q;
  logic [W-1:0]             acc_q, acc_d;
  logic [W-1:0]             opa_q, opa_d;
  logic [W-1:0]             res_q, res_d;
  logic [W-1:0]             prod_q;
  logic [W-1:0]             digest_q, digest_d;
  logic                     out_valid_q, out_valid_d;

  logic [W-1:0]             const_b;
  logic [H-1:0]             mul_a, mul_b;
  logic [W-1:0]             prod_d;
  logic [W-1:0]             mul_res;
  logic [W-1:0]             masked_word;
  logic [mrh_pkg::CountW-1:0] count_clamped;
  logic [W-1:0]             seed;
  logic [W-1:0]             mix_t;
  logic [W-1:0]             round_sum;
  logic                     in_xfer;
  logic                     out_xfer;
  logic                     out_free;

  assign in_xfer  = in_i.valid & in_i.ready;
  assign out_xfer = out_o.valid & out_o.ready;
  assign out_free = ~out_valid_q | out_o.ready;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.digest = digest_q;

  // Clear bytes at or above the byte count; counts above eight keep the whole word.
  always_comb begin
    count_clamped = (in_i.byte_count > mrh_pkg::CountW'(mrh_pkg::BytesPerWord)) ?
                    mrh_pkg::CountW'(mrh_pkg::BytesPerWord) : in_i.byte_count;
    for (int i = 0; i < int'(mrh_pkg::BytesPerWord); i++) begin
      masked_word[8*i +: 8] = (mrh_pkg::CountW'(i) < count_clamped) ?
                              in_i.data_word[8*i +: 8] : 8'h00;
    end
  end

  assign seed = in_msg_q ? acc_q :
                (mrh_pkg::MixPrimeA ^ {{(W-mrh_pkg::LenW){1'b0}}, len_q});

  // Shared 32x32 multiplier; the low 64 bits of a 64x64 product need three partials.
  // The last step repeats the third partial so the product holds through a stall.
  assign const_b = (op_q == OP_ABS_A || op_q == OP_FIN_A) ? mrh_pkg::MixPrimeA
                                                          : mrh_pkg::MixPrimeB;
  always_comb begin
    case (cnt_q)
      2'd1: begin
        mul_a = opa_q[H-1:0];
        mul_b = const_b[W-1:H];
      end
      2'd2, STEP_LAST: begin
        mul_a = opa_q[W-1:H];
        mul_b = const_b[H-1:0];
      end
      default: begin
        mul_a = opa_q[H-1:0];
        mul_b = const_b[H-1:0];
      end
    endcase
  end
  assign prod_d = W'(mul_a) * W'(mul_b);

  // Complete product, valid in the last step of a multiply.
  assign mul_res   = {res_q[W-1:H] + prod_q[H-1:0], res_q[H-1:0]};
  assign mix_t     = acc_q ^ mul_res;
  assign round_sum = mul_res + mrh_pkg::MixAddend;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    in_msg_d    = in_msg_q;
    last_d      = last_q;
    acc_d       = acc_q;
    opa_d       = opa_q;
    res_d       = res_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          acc_d    = seed;
          last_d   = in_i.last;
          in_msg_d = ~in_i.last;
          cnt_d    = 2'd0;
          if (count_clamped != '0) begin
            opa_d   = masked_word;
            op_d    = OP_ABS_A;
            state_d = ST_MUL;
          end else if (in_i.last) begin
            opa_d   = seed ^ (seed >> mrh_pkg::FinShift1);
            op_d    = OP_FIN_A;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        case (cnt_q)
          2'd0: begin
            cnt_d = 2'd1;
          end
          2'd1: begin
            res_d = prod_q;
            cnt_d = 2'd2;
          end
          2'd2: begin
            res_d[W-1:H] = res_q[W-1:H] + prod_q[H-1:0];
            cnt_d        = STEP_LAST;
          end
          default: begin
            cnt_d = 2'd0;
            case (op_q)
              OP_ABS_A: begin
                opa_d = {mix_t[W-1-mrh_pkg::RoundRot:0],
                         mix_t[W-1:W-mrh_pkg::RoundRot]};
                op_d  = OP_ABS_B;
              end
              OP_ABS_B: begin
                acc_d = round_sum;
                if (last_q) begin
                  opa_d = round_sum ^ (round_sum >> mrh_pkg::FinShift1);
                  op_d  = OP_FIN_A;
                end else begin
                  state_d = ST_IDLE;
                end
              end
              OP_FIN_A: begin
                opa_d = mul_res ^ (mul_res >> mrh_pkg::FinShift2);
                op_d  = OP_FIN_B;
              end
              default: begin
                // Hold the finished product until the digest register is free.
                if (out_free) begin
                  digest_d    = mul_res ^ (mul_res >> mrh_pkg::FinShift3);
                  out_valid_d = 1'b1;
                  state_d     = ST_IDLE;
                end else begin
                  cnt_d = STEP_LAST;
                end
              end
            endcase
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ABS_A;
      cnt_q       <= 2'd0;
      in_msg_q    <= 1'b0;
      last_q      <= 1'b0;
      len_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      in_msg_q    <= in_msg_d;
      last_q      <= last_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q    <= opa_d;
    res_q    <= res_d;
    prod_q   <= prod_d;
    digest_q <= digest_d;
  end

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == 2'd0))
    else $error("step counter left nonzero while idle");

  a_digest_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && op_q == OP_FIN_B && cnt_q == STEP_LAST && out_free)
    |=> (out_o.valid && state_q == ST_IDLE))
    else $error("finished digest was not presented");

  a_empty_word_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !in_i.last && in_i.byte_count == '0) |=> (state_q == ST_IDLE))
    else $error("empty non-final word did not return to idle");

  a_last_ends_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.last) |=> !in_msg_q)
    else $error("message state not cleared by final word");

  a_no_digest_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(digest_q)))
    else $error("pending digest was overwritten");

endmodule
